// File: hw/rtl/bmf_pkg.sv
// bmf_pkg: shared types and fixed constants of the block median filter
// used by bmf_cell and block_median_filter; no dependencies

package bmf_pkg;

    // width of the window size register
    localparam int CFG_W = 6;
    localparam logic [CFG_W-1:0] WINDOW_RESET = 6'd5;

    // command codes carried in s_tuser
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // control broadcast from the sequencer to every cell of the row
    typedef struct packed {
        logic insert;   // sorted insert of the new sample
        logic shift;    // move every cell one place toward the head
        logic flush;    // mark all cells empty
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_SCAN = 2'b10
    } seq_state_t;

endpackage

// File: hw/rtl/block_median_filter.sv
// block_median_filter: non-overlapping block median over a row of sorting cells
// depends on bmf_pkg and bmf_cell
//
//  channel | ports                                | beat
//  --------+--------------------------------------+------------------------------------
//  input   | s_tvalid s_tready s_tdata s_tuser    | one sample or one clear command
//  output  | m_tvalid m_tready m_tdata m_tuser    | one result for every input beat
//  config  | cfg_valid cfg_ready cfg_data         | window size, taken at any time
//
// one input beat per cycle while m_tready is high and no scan runs; each result is
// sent from the output register. a push that finds at least as many samples held
// as the window (window shrunk mid-block) scans the cell row from its head with
// s_tready low. reset empties the row at once (per-cell occupied bits), no sweep.
// a stalled output stops s_tready only when the output register is full and not drained.

module block_median_filter
    import bmf_pkg::*;
#(
    parameter int MAX_WINDOW   = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,   // [SAMPLE_WIDTH-1:0] sample
    input  logic                                  s_tuser,   // [0] cmd
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_tdata,   // [SAMPLE_WIDTH-1:0] median
    output logic                                  m_tuser,   // [0] valid_res
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [CFG_W-1:0]                      cfg_data
);

    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int TAG_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    logic [CFG_W-1:0]        win_reg;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [CNT_W-1:0]        seen_reg, seen_next;
    seq_state_t              state_reg, state_next;
    logic                    m_valid_reg, m_valid_next;
    logic [SAMPLE_WIDTH-1:0] m_data_reg, m_data_next;
    logic                    m_user_reg, m_user_next;

    logic [CMP_W-1:0]        win_ext;
    logic [CMP_W-1:0]        n_ext;
    logic [CNT_W-1:0]        win_n;
    logic [CNT_W-1:0]        half_cnt;
    logic [TAG_W-1:0]        half_idx;
    logic [CNT_W-1:0]        fill_inc;
    logic [SAMPLE_WIDTH-1:0] sample;
    logic                    accept;
    logic                    load;
    logic                    head_hit;
    cell_ctrl_t              ctrl;

    logic [SAMPLE_WIDTH-1:0] cell_val [MAX_WINDOW];
    logic [TAG_W-1:0]        cell_tag [MAX_WINDOW];
    logic                    cell_occ [MAX_WINDOW];
    logic                    cell_keep [MAX_WINDOW];
    logic [SAMPLE_WIDTH-1:0] cell_ins [MAX_WINDOW];

    // effective window: zero means one, above the row length saturates
    assign win_ext = CMP_W'(win_reg);
    always_comb begin
        if (win_ext == '0) begin
            n_ext = CMP_W'(1);
        end else if (win_ext > CMP_W'(MAX_WINDOW)) begin
            n_ext = CMP_W'(MAX_WINDOW);
        end else begin
            n_ext = win_ext;
        end
    end
    assign win_n    = CNT_W'(n_ext);
    assign half_cnt = win_n >> 1;
    assign half_idx = TAG_W'(half_cnt);
    assign fill_inc = fill_reg + CNT_W'(1);
    assign sample   = s_tdata[SAMPLE_WIDTH-1:0];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_RUN) && (!m_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;

    // head of the row during a scan: one of the first win_n samples of the block
    assign head_hit = cell_occ[0] && (CNT_W'(cell_tag[0]) < win_n);

    always_comb begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        seen_next   = seen_reg;
        ctrl        = '0;
        load        = 1'b0;
        m_data_next = m_data_reg;
        m_user_next = m_user_reg;
        case (state_reg)
            ST_RUN: begin
                if (accept) begin
                    load        = 1'b1;
                    m_data_next = '0;
                    m_user_next = 1'b0;
                    if (s_tuser == CMD_CLEAR) begin
                        fill_next  = '0;
                        ctrl.flush = 1'b1;
                    end else if (fill_reg < win_n) begin
                        if (fill_inc == win_n) begin
                            m_data_next = cell_ins[half_idx];
                            m_user_next = 1'b1;
                            fill_next   = '0;
                            ctrl.flush  = 1'b1;
                        end else begin
                            fill_next   = fill_inc;
                            ctrl.insert = 1'b1;
                        end
                    end else begin
                        // at least as many held as the window: find the median by scanning
                        load       = 1'b0;
                        seen_next  = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (head_hit && (seen_reg == half_cnt)) begin
                    load        = 1'b1;
                    m_data_next = cell_val[0];
                    m_user_next = 1'b1;
                    fill_next   = '0;
                    ctrl.flush  = 1'b1;
                    state_next  = ST_RUN;
                end else begin
                    ctrl.shift = 1'b1;
                    if (head_hit) begin
                        seen_next = seen_reg + CNT_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_comb begin
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg     <= WINDOW_RESET;
            fill_reg    <= '0;
            seen_reg    <= '0;
            state_reg   <= ST_RUN;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                win_reg <= cfg_data;
            end
            fill_reg    <= fill_next;
            seen_reg    <= seen_next;
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'(m_data_reg);
    assign m_tuser  = m_user_reg;

    // row of cells, head at index 0 holds the smallest sample
    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        logic [SAMPLE_WIDTH-1:0] l_val, r_val;
        logic [TAG_W-1:0]        l_tag, r_tag;
        logic                    l_occ, l_keep, r_occ;

        if (i == 0) begin : g_head
            assign l_val  = '0;
            assign l_tag  = '0;
            assign l_occ  = 1'b0;
            assign l_keep = 1'b1;
        end else begin : g_mid
            assign l_val  = cell_val[i-1];
            assign l_tag  = cell_tag[i-1];
            assign l_occ  = cell_occ[i-1];
            assign l_keep = cell_keep[i-1];
        end

        if (i == MAX_WINDOW - 1) begin : g_tail
            assign r_val = '0;
            assign r_tag = '0;
            assign r_occ = 1'b0;
        end else begin : g_body
            assign r_val = cell_val[i+1];
            assign r_tag = cell_tag[i+1];
            assign r_occ = cell_occ[i+1];
        end

        bmf_cell #(
            .DATA_W (SAMPLE_WIDTH),
            .TAG_W  (TAG_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .new_val   (sample),
            .new_tag   (TAG_W'(fill_reg)),
            .left_val  (l_val),
            .left_tag  (l_tag),
            .left_occ  (l_occ),
            .left_keep (l_keep),
            .right_val (r_val),
            .right_tag (r_tag),
            .right_occ (r_occ),
            .val       (cell_val[i]),
            .tag       (cell_tag[i]),
            .occ       (cell_occ[i]),
            .keep      (cell_keep[i]),
            .ins_val   (cell_ins[i])
        );
    end

endmodule

// File: hw/rtl/bmf_cell.sv
// bmf_cell: one place of the sorted insertion row, holding a sample and its arrival tag
// depends on bmf_pkg

module bmf_cell
    import bmf_pkg::*;
#(
    parameter int DATA_W = 16,
    parameter int TAG_W  = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cell_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] new_val,
    input  logic [TAG_W-1:0]  new_tag,
    input  logic [DATA_W-1:0] left_val,
    input  logic [TAG_W-1:0]  left_tag,
    input  logic              left_occ,
    input  logic              left_keep,
    input  logic [DATA_W-1:0] right_val,
    input  logic [TAG_W-1:0]  right_tag,
    input  logic              right_occ,
    output logic [DATA_W-1:0] val,
    output logic [TAG_W-1:0]  tag,
    output logic              occ,
    output logic              keep,
    output logic [DATA_W-1:0] ins_val
);

    logic [DATA_W-1:0] val_reg, val_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic              occ_reg, occ_next;
    logic [TAG_W-1:0]  ins_tag;
    logic              ins_occ;

    // an occupied cell not above the new sample stays in place
    assign keep = occ_reg && ($signed(val_reg) <= $signed(new_val));

    always_comb begin
        if (keep) begin
            ins_val = val_reg;
            ins_tag = tag_reg;
            ins_occ = occ_reg;
        end else if (left_keep) begin
            ins_val = new_val;
            ins_tag = new_tag;
            ins_occ = 1'b1;
        end else begin
            ins_val = left_val;
            ins_tag = left_tag;
            ins_occ = left_occ;
        end
    end

    always_comb begin
        val_next = val_reg;
        tag_next = tag_reg;
        occ_next = occ_reg;
        if (ctrl.flush) begin
            occ_next = 1'b0;
        end else if (ctrl.insert) begin
            val_next = ins_val;
            tag_next = ins_tag;
            occ_next = ins_occ;
        end else if (ctrl.shift) begin
            val_next = right_val;
            tag_next = right_tag;
            occ_next = right_occ;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        tag_reg <= tag_next;
    end

    assign val = val_reg;
    assign tag = tag_reg;
    assign occ = occ_reg;

endmodule

// File: bench/block_median_filter_test.sv
// block_median_filter_test: self-checking bench for the non-overlapping block median filter
// drives sample/clear beats and window sizes, predicts results with its model or a typed row
// depends on bmf_pkg and block_median_filter

module block_median_filter_test;
    import bmf_pkg::*;

    localparam int MAX_WIN         = 32;
    localparam int SW              = 16;
    localparam int DW              = ((SW + 7) / 8) * 8;
    localparam int PHASES          = 22;
    localparam int BEATS_PER_PHASE = 75;
    localparam int STALL_PHASE     = 2;
    localparam int STALL_CYCLES    = 300;
    localparam int TAIL_CYCLES     = 40;
    localparam int CYCLE_LIMIT     = 500000;

    localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};

    typedef struct packed {
        logic [SW-1:0] median;
        logic          valid_res;
    } medres_t;

    typedef struct packed {
        logic          cmd;
        logic [SW-1:0] sample;
        logic          typed;       // expected result given in the row
        logic [SW-1:0] exp_median;
        logic          exp_valid;
    } dir_row_t;

    // window 5 after reset
    localparam dir_row_t DIRECTED [24] = '{
        '{CMD_PUSH,  16'd100,  1'b1, 16'h0000, 1'b0},
        '{CMD_PUSH,  S_MIN,    1'b1, 16'h0000, 1'b0},
        '{CMD_PUSH,  S_MAX,    1'b1, 16'h0000, 1'b0},
        '{CMD_PUSH,  16'hFFFB, 1'b1, 16'h0000, 1'b0},
        '{CMD_PUSH,  16'd7,    1'b1, 16'd7,    1'b1},
        // partial window dropped by a clear
        '{CMD_PUSH,  16'd9,    1'b1, 16'h0000, 1'b0},
        '{CMD_PUSH,  16'hFFF7, 1'b1, 16'h0000, 1'b0},
        '{CMD_CLEAR, 16'h0000, 1'b1, 16'h0000, 1'b0},
        '{CMD_PUSH,  S_MIN,    1'b1, 16'h0000, 1'b0},
        '{CMD_PUSH,  S_MIN,    1'b1, 16'h0000, 1'b0},
        '{CMD_PUSH,  S_MIN,    1'b1, 16'h0000, 1'b0},
        '{CMD_PUSH,  S_MIN,    1'b1, 16'h0000, 1'b0},
        '{CMD_PUSH,  S_MIN,    1'b1, S_MIN,    1'b1},
        '{CMD_PUSH,  S_MAX,    1'b1, 16'h0000, 1'b0},
        '{CMD_PUSH,  S_MAX,    1'b1, 16'h0000, 1'b0},
        '{CMD_PUSH,  S_MAX,    1'b1, 16'h0000, 1'b0},
        '{CMD_PUSH,  S_MAX,    1'b1, 16'h0000, 1'b0},
        '{CMD_PUSH,  S_MAX,    1'b1, S_MAX,    1'b1},
        // clear on an empty window, sample bits ignored
        '{CMD_CLEAR, 16'hA5A5, 1'b1, 16'h0000, 1'b0},
        '{CMD_PUSH,  16'd5,    1'b0, 16'h0000, 1'b0},
        '{CMD_PUSH,  16'd4,    1'b0, 16'h0000, 1'b0},
        '{CMD_PUSH,  16'd3,    1'b0, 16'h0000, 1'b0},
        '{CMD_PUSH,  16'd2,    1'b0, 16'h0000, 1'b0},
        '{CMD_PUSH,  16'd1,    1'b0, 16'h0000, 1'b0}
    };

    // ordered so that a small size often follows a partly filled large window
    localparam logic [CFG_W-1:0] WINDOW_PLAN [16] = '{
        6'd0, 6'd32, 6'd3, 6'd63, 6'd2, 6'd33, 6'd1, 6'd20,
        6'd4, 6'd31, 6'd6, 6'd16, 6'd2, 6'd8, 6'd24, 6'd7
    };

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [DW-1:0]     s_tdata;     // [SW-1:0] sample
    logic              s_tuser;     // [0] cmd
    logic              m_tvalid;
    logic              m_tready;
    logic [DW-1:0]     m_tdata;     // [SW-1:0] median
    logic              m_tuser;     // [0] valid_res
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data;

    // predictor state
    logic signed [SW-1:0] block_store [MAX_WIN];
    int unsigned          held_count = 0;
    logic [CFG_W-1:0]     window_reg = WINDOW_RESET;

    medres_t     median_q [$];
    logic        idle_on      = 1'b1;
    logic        stall_req    = 1'b0;
    int          stall_left   = 0;
    int unsigned cycle_count  = 0;
    int          fail_count   = 0;
    int          beats_sent   = 0;
    int          results_seen = 0;
    int          medians_seen = 0;
    int          sizes_written = 0;

    block_median_filter #(
        .MAX_WINDOW   (MAX_WIN),
        .SAMPLE_WIDTH (SW)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // one beat into the window: returns the result beat it causes
    function automatic medres_t predict_median(input logic cmd, input logic [SW-1:0] smp);
        medres_t              r;
        int unsigned          n;
        int unsigned          i;
        int unsigned          k;
        logic signed [SW-1:0] probe;
        r.median    = '0;
        r.valid_res = 1'b0;
        if (window_reg == 0)
            n = 1;
        else if (window_reg > MAX_WIN)
            n = MAX_WIN;
        else
            n = window_reg;
        if (cmd == CMD_CLEAR) begin
            held_count = 0;
            return r;
        end
        if (held_count < MAX_WIN)
            block_store[held_count] = smp;
        held_count++;
        if (held_count < n)
            return r;
        // only the first n entries take part, even when more are held
        for (i = 1; i < n; i++) begin
            probe = block_store[i];
            k = i;
            while (k > 0 && block_store[k-1] > probe) begin
                block_store[k] = block_store[k-1];
                k--;
            end
            block_store[k] = probe;
        end
        r.median    = block_store[(n / 2) % MAX_WIN];
        r.valid_res = 1'b1;
        held_count  = 0;
        return r;
    endfunction

    function automatic logic [SW-1:0] pick_sample();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        case (sel)
            0: begin
                case ($urandom_range(0, 3))
                    0: return S_MIN;
                    1: return S_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1, 2: return SW'($urandom_range(0, 8)) - SW'(4);   // many ties
            default: return SW'($urandom);
        endcase
    endfunction

    // leaves s_tvalid high at the negedge after the beat is taken
    task automatic send_beat(input logic cmd, input logic [SW-1:0] smp,
                             input logic use_given, input medres_t given);
        medres_t r;
        while (idle_on && $urandom_range(0, 99) < 23) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= DW'(smp);
        do @(posedge aclk); while (!s_tready);
        r = predict_median(cmd, smp);
        median_q.push_back(use_given ? given : r);
        beats_sent++;
        @(negedge aclk);
    endtask

    // only with nothing in flight
    task automatic write_window(input logic [CFG_W-1:0] w);
        while (median_q.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do @(posedge aclk); while (!cfg_ready);
        window_reg = w;
        sizes_written++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        medres_t          given;
        logic [CFG_W-1:0] w;
        logic             cmd;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_PUSH;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        aclk      = 1'b0;
        aresetn   = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[i]) begin
            given.median    = DIRECTED[i].exp_median;
            given.valid_res = DIRECTED[i].exp_valid;
            send_beat(DIRECTED[i].cmd, DIRECTED[i].sample, DIRECTED[i].typed, given);
        end
        s_tvalid <= 1'b0;

        given = '0;
        for (int phase = 0; phase < PHASES; phase++) begin
            w = (phase < 16) ? WINDOW_PLAN[phase] : CFG_W'($urandom_range(0, 63));
            write_window(w);
            idle_on = (phase < 8 || phase > 10);
            if (phase == STALL_PHASE)
                stall_req = 1'b1;
            repeat (BEATS_PER_PHASE) begin
                cmd = ($urandom_range(0, 399) < 8) ? CMD_CLEAR : CMD_PUSH;
                send_beat(cmd, pick_sample(), 1'b0, given);
            end
            s_tvalid <= 1'b0;
        end

        while (median_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("%0d beats sent, %0d result beats checked, %0d of them completed medians",
                 beats_sent, results_seen, medians_seen);
        $display("%0d window sizes written, zero, one, full and saturating among them",
                 sizes_written);
        if (fail_count == 0)
            $display("block_median_filter verification clean");
        else
            $display("block_median_filter verification failed");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off so the row backs up
    always @(negedge aclk) begin
        if (stall_req) begin
            stall_left = STALL_CYCLES;
            stall_req  = 1'b0;
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= !(idle_on && $urandom_range(0, 99) < 23);
        end
    end

    always @(posedge aclk) begin : result_check
        medres_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (median_q.size() == 0) begin
                $error("result beat with nothing expected: median %0d valid_res %0b",
                       $signed(m_tdata[SW-1:0]), m_tuser);
                fail_count++;
            end else begin
                want = median_q.pop_front();
                results_seen++;
                if (want.valid_res)
                    medians_seen++;
                if (m_tdata[SW-1:0] !== want.median) begin
                    $error("median: expected %0d, got %0d",
                           $signed(want.median), $signed(m_tdata[SW-1:0]));
                    fail_count++;
                end
                if (m_tuser !== want.valid_res) begin
                    $error("valid_res: expected %0b, got %0b", want.valid_res, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, median_q.size());
            $display("block_median_filter verification failed");
            $finish;
        end
    end

endmodule
